// ===== rtl/lbvs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbvs_pkg
// Types, codes and helpers shared by the skinning engine.
// ----------------------------------------------------------------------------
package lbvs_pkg;

    localparam int ENTRIES_PER_BONE = 12;
    localparam int BONE_SLOTS_DEF   = 64;
    localparam int PA_W             = 52;   // position partial sum
    localparam int NA_W             = 35;   // normal partial sum
    localparam int MA_W             = 35;   // multiplier operand a
    localparam int MB_W             = 33;   // multiplier operand b
    localparam int MP_W             = MA_W + MB_W;

    localparam logic OP_MATRIX    = 1'b0;
    localparam logic OP_INFLUENCE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         bone_index;
        logic [3:0]         matrix_entry;
        logic signed [31:0] matrix_value;
        logic [15:0]        weight;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               last_influence;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] skinned_z;
        logic signed [15:0] unit_nx;
        logic signed [15:0] unit_ny;
        logic signed [15:0] unit_nz;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DRAIN,
        ST_LOAD,
        ST_SHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } t_state;

    // what the product register holds
    typedef enum logic [2:0] {
        M_NONE,
        M_POS,
        M_NRM,
        M_PW,
        M_NW,
        M_SQ
    } t_mop;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/linear_blend_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Bone palette skinning: blends transformed positions and normals over the
// influences of a vertex and returns the position and the unit normal.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+----------------------
//  input    | i_in_valid  | o_in_stall   | i_in_data  (t_in_item)
//  output   | o_out_valid | i_out_stall  | o_out_data (t_out_item)
//
//  matrix write: straight into the palette memory
//  influence: reads of every palette entry of the bone through the single memory
//    port, passes through the shared multiplier, one drain
//  last influence adds a load, a shift search, squaring, a bit-serial square
//    root, three divides and an output step; one item is in work at a time
//  reset is synchronous active low; the palette is not cleared
//  a result waits in the output register while the next transaction is taken
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning
    import lbvs_pkg::*;
#(
    parameter int BONE_SLOTS = BONE_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int DEPTH = BONE_SLOTS * ENTRIES_PER_BONE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;
    logic [4:0] r_k;
    logic [1:0] r_c;

    t_in_item r_item;
    logic     r_bone_ok;

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rd_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en, in_acc;

    logic signed [31:0] r_rot   [9];
    logic signed [31:0] r_trans [3];

    logic signed [PA_W-1:0] r_pa;
    logic signed [NA_W-1:0] r_na;
    logic signed [63:0]     r_psum [3];
    logic signed [63:0]     r_nsum [3];

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    t_mop                   iss_op;
    logic signed [MP_W-1:0] r_prod;
    t_mop                   r_pk;
    logic [1:0]             r_pc;

    logic [63:0] r_mag [3];
    logic [63:0] r_mx;
    logic        r_neg [3];
    logic [63:0] r_len2, r_root, r_bit;
    logic [31:0] r_rem;
    logic [16:0] r_num_lo, r_q;
    logic signed [15:0] r_unit [3];

    logic signed [31:0] pos_v [3];
    logic signed [15:0] nrm_v [3];
    logic [3:0]         rot_idx;
    logic [1:0]         op_row;
    logic [63:0]        sq_t;
    logic [45:0]        dv_num;
    logic [32:0]        dv_try;
    logic [31:0]        dv_rem_n;
    logic [16:0]        dv_q_n;
    logic signed [15:0] dv_unit;
    logic [63:0]        ld_mag [3];
    logic [63:0]        ld_mx;

    t_out_item r_out;
    logic      r_out_valid, out_load;

    assign in_acc = i_in_valid && !o_in_stall;
    assign wr_en  = in_acc && (i_in_data.opcode == OP_MATRIX)
                    && (32'(i_in_data.bone_index) < BONE_SLOTS)
                    && (i_in_data.matrix_entry < 4'(ENTRIES_PER_BONE));
    assign wr_addr = AW'(32'(i_in_data.bone_index) * ENTRIES_PER_BONE
                         + 32'(i_in_data.matrix_entry));

    always_comb begin
        rd_addr = '0;
        if (r_bone_ok && r_k < 5'(ENTRIES_PER_BONE)) begin
            rd_addr = AW'(32'(r_item.bone_index) * ENTRIES_PER_BONE + 32'(r_k));
        end
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_in_data.matrix_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign pos_v[0] = r_item.pos_x;
    assign pos_v[1] = r_item.pos_y;
    assign pos_v[2] = r_item.pos_z;
    assign nrm_v[0] = r_item.norm_x;
    assign nrm_v[1] = r_item.norm_y;
    assign nrm_v[2] = r_item.norm_z;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_data.opcode == OP_INFLUENCE) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_k == 5'(ENTRIES_PER_BONE)) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_c == 2'd2 && r_k == 5'd7) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = r_item.last_influence ? ST_LOAD : ST_IDLE;
            ST_LOAD:   n_state = ST_SHIFT;
            ST_SHIFT: begin
                if (r_mx == '0) begin
                    n_state = ST_OUT;
                end else if (!(|r_mx[63:30]) && (|r_mx[29]))  begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (r_k == 5'd3) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_k == 5'd31) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_c == 2'd2 && r_k == 5'd17) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: stall and multiplier operands
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        out_load   = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
        op_row     = (r_k < 5'd3) ? r_k[1:0] : 2'(r_k - 5'd3);
        rot_idx    = 4'(op_row) * 4'd3 + 4'(r_c);
        mul_a      = '0;
        mul_b      = '0;
        iss_op     = M_NONE;
        unique case (r_state)
            ST_MAC: begin
                if (r_k < 5'd3) begin
                    mul_a  = MA_W'(r_rot[rot_idx]);
                    mul_b  = MB_W'(pos_v[op_row]);
                    iss_op = M_POS;
                end else if (r_k < 5'd6) begin
                    mul_a  = MA_W'(r_rot[rot_idx]);
                    mul_b  = MB_W'(nrm_v[op_row]);
                    iss_op = M_NRM;
                end else if (r_k == 5'd6) begin
                    mul_a  = MA_W'(sat32(64'(r_pa)));
                    mul_b  = MB_W'({1'b0, r_item.weight});
                    iss_op = M_PW;
                end else begin
                    mul_a  = r_na;
                    mul_b  = MB_W'({1'b0, r_item.weight});
                    iss_op = M_NW;
                end
            end
            ST_SQUARE: begin
                if (r_k < 5'd3) begin
                    mul_a  = MA_W'({1'b0, r_mag[r_k[1:0]][29:0]});
                    mul_b  = MB_W'({1'b0, r_mag[r_k[1:0]][29:0]});
                    iss_op = M_SQ;
                end
            end
            default: ;
        endcase
    end

    // magnitudes of the normal sums and their largest
    always_comb begin
        ld_mx = '0;
        for (int i = 0; i < 3; i++) begin
            ld_mag[i] = r_nsum[i][63] ? 64'(-r_nsum[i]) : 64'(r_nsum[i]);
            if (ld_mag[i] > ld_mx) begin
                ld_mx = ld_mag[i];
            end
        end
    end

    // root step and divide step
    always_comb begin
        sq_t     = r_root + r_bit;
        dv_num   = {1'b0, r_mag[r_c][29:0], 15'd0} + 46'(r_root[31:1]);
        dv_try   = {r_rem, r_num_lo[16]} - {1'b0, r_root[31:0]};
        dv_rem_n = dv_try[32] ? {r_rem[30:0], r_num_lo[16]} : dv_try[31:0];
        dv_q_n   = {r_q[15:0], !dv_try[32]};
        if (r_neg[r_c]) begin
            dv_unit = 16'(-dv_q_n);
        end else if (dv_q_n > 17'd32767) begin
            dv_unit = 16'sh7fff;
        end else begin
            dv_unit = dv_q_n[15:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_c         <= '0;
            r_pk        <= M_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pk    <= iss_op;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (n_state != r_state) begin
                r_k <= '0;
                r_c <= '0;
            end else if ((r_state == ST_MAC && r_k == 5'd7)
                         || (r_state == ST_DIV && r_k == 5'd17)) begin
                r_k <= '0;
                r_c <= r_c + 2'd1;
            end else begin
                r_k <= r_k + 5'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_pc   <= r_c;

        if (in_acc) begin
            r_item    <= i_in_data;
            r_bone_ok <= (32'(i_in_data.bone_index) < BONE_SLOTS);
        end

        if (r_state == ST_READ && r_k != '0) begin
            if (r_k <= 5'd9) begin
                r_rot[4'(r_k - 5'd1)] <= r_bone_ok ? r_rd_data : '0;
            end else begin
                r_trans[2'(r_k - 5'd10)] <= r_bone_ok ? r_rd_data : '0;
            end
        end

        if (r_state == ST_MAC && r_k == '0) begin
            r_pa <= PA_W'(r_trans[r_c]);
            r_na <= '0;
        end else if (r_pk == M_POS) begin
            r_pa <= r_pa + PA_W'(r_prod >>> 16);
        end else if (r_pk == M_NRM) begin
            r_na <= r_na + NA_W'(r_prod >>> 16);
        end

        if (r_pk == M_PW) begin
            r_psum[r_pc] <= sat_add64(r_psum[r_pc], 64'(r_prod >>> 15));
        end
        if (r_pk == M_NW) begin
            r_nsum[r_pc] <= sat_add64(r_nsum[r_pc], 64'(r_prod >>> 15));
        end

        // magnitudes and shift search, one bit per cycle
        if (r_state == ST_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_nsum[i][63];
                r_mag[i] <= ld_mag[i];
            end
            r_mx <= ld_mx;
        end
        if (r_state == ST_SHIFT) begin
            if (r_mx == '0) begin
                for (int i = 0; i < 3; i++) begin
                    r_unit[i] <= '0;
                end
            end else if (|r_mx[63:30]) begin
                r_mx <= r_mx >> 1;
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= r_mag[i] >> 1;
                end
            end else if (!r_mx[29]) begin
                r_mx <= r_mx << 1;
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= r_mag[i] << 1;
                end
            end
        end

        if (r_state == ST_SQUARE && r_k == '0) begin
            r_len2 <= '0;
            r_root <= '0;
            r_bit  <= 64'd1 << 62;
        end else if (r_pk == M_SQ) begin
            r_len2 <= r_len2 + 64'(r_prod);
        end

        if (r_state == ST_SQRT) begin
            if (r_len2 >= sq_t) begin
                r_len2 <= r_len2 - sq_t;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end

        if (r_state == ST_DIV) begin
            if (r_k == '0) begin
                r_rem    <= 32'(dv_num[45:17]);
                r_num_lo <= dv_num[16:0];
                r_q      <= '0;
            end else begin
                r_rem    <= dv_rem_n;
                r_num_lo <= {r_num_lo[15:0], 1'b0};
                r_q      <= dv_q_n;
                if (r_k == 5'd17) begin
                    r_unit[r_c] <= dv_unit;
                end
            end
        end

        if (out_load) begin
            r_out.skinned_x <= sat32(r_psum[0]);
            r_out.skinned_y <= sat32(r_psum[1]);
            r_out.skinned_z <= sat32(r_psum[2]);
            r_out.unit_nx   <= r_unit[0];
            r_out.unit_ny   <= r_unit[1];
            r_out.unit_nz   <= r_unit[2];
        end

        if (!i_rst_n || out_load) begin
            for (int i = 0; i < 3; i++) begin
                r_psum[i] <= '0;
                r_nsum[i] <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== test/linear_blend_vertex_skinning_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_checker
// Watches both channels of the skinning engine, predicts each vertex result
// from its own copy of the bone palette and accumulators, compares in order.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_checker
    import lbvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_vertex_count
);

    localparam int SLOTS = 64;

    logic signed [31:0] palette [SLOTS*ENTRIES_PER_BONE];
    logic signed [63:0] pos_acc [3];
    logic signed [63:0] nrm_acc [3];
    t_out_item          vertex_q [$];

    function automatic logic signed [63:0] fshift(input logic signed [63:0] v,
                                                  input int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic blend_influence(input t_in_item it, output bit done,
                                   output t_out_item res);
        logic signed [63:0] e [12];
        logic signed [63:0] p [3];
        logic signed [63:0] n [3];
        logic signed [63:0] pa;
        logic signed [63:0] na;
        logic signed [63:0] w;
        logic [63:0]        mag [3];
        logic [63:0]        mx;
        logic [63:0]        len2;
        logic [63:0]        len;
        logic [63:0]        q;
        logic signed [63:0] v;
        logic               neg [3];
        logic signed [15:0] u [3];
        done = 0;
        res = '0;
        w = {48'd0, it.weight};
        p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
        n[0] = it.norm_x; n[1] = it.norm_y; n[2] = it.norm_z;
        for (int r = 0; r < 12; r++) begin
            e[r] = (it.bone_index < SLOTS) ? palette[it.bone_index*12 + r] : 64'sd0;
        end
        for (int c = 0; c < 3; c++) begin
            pa = e[9+c];
            na = 0;
            for (int r = 0; r < 3; r++) begin
                pa = pa + fshift(e[3*r+c] * p[r], 16);
                na = na + fshift(e[3*r+c] * n[r], 16);
            end
            pa = sat32(pa);
            pos_acc[c] = sat_add64(pos_acc[c], fshift(pa * w, 15));
            nrm_acc[c] = sat_add64(nrm_acc[c], fshift(na * w, 15));
        end
        if (!it.last_influence) return;
        done = 1;
        mx = 0;
        for (int c = 0; c < 3; c++) begin
            neg[c] = nrm_acc[c] < 0;
            mag[c] = neg[c] ? 64'd0 - nrm_acc[c] : nrm_acc[c];
            if (mag[c] > mx) mx = mag[c];
            u[c] = 0;
        end
        if (mx != 0) begin
            while (mx >= (64'd1 << 30)) begin
                mx = mx >> 1;
                for (int c = 0; c < 3; c++) mag[c] = mag[c] >> 1;
            end
            while (mx < (64'd1 << 29)) begin
                mx = mx << 1;
                for (int c = 0; c < 3; c++) mag[c] = mag[c] << 1;
            end
            len2 = 0;
            for (int c = 0; c < 3; c++) len2 = len2 + mag[c] * mag[c];
            len = root64(len2);
            if (len != 0) begin
                for (int c = 0; c < 3; c++) begin
                    q = (mag[c] * 32768 + len / 2) / len;
                    v = neg[c] ? -$signed(q) : $signed(q);
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                    u[c] = v[15:0];
                end
            end
        end
        res.skinned_x = sat32(pos_acc[0]);
        res.skinned_y = sat32(pos_acc[1]);
        res.skinned_z = sat32(pos_acc[2]);
        res.unit_nx = u[0];
        res.unit_ny = u[1];
        res.unit_nz = u[2];
        for (int c = 0; c < 3; c++) begin
            pos_acc[c] = 0;
            nrm_acc[c] = 0;
        end
    endtask

    always @(posedge i_clk) begin
        bit        done;
        t_out_item res;
        t_out_item want;
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                pos_acc[c] = 0;
                nrm_acc[c] = 0;
            end
            o_fail_count   <= 0;
            o_vertex_count <= 0;
            o_pending      <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.opcode == OP_MATRIX) begin
                    if (i_in_data.bone_index < SLOTS && i_in_data.matrix_entry < 12)
                        palette[i_in_data.bone_index*12 + i_in_data.matrix_entry] =
                            i_in_data.matrix_value;
                end else begin
                    blend_influence(i_in_data, done, res);
                    if (done) vertex_q.insert(vertex_q.size(), res);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (vertex_q.size() == 0) begin
                    $display("%0t: unexpected vertex result %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = vertex_q.pop_front();
                    o_vertex_count <= o_vertex_count + 1;
                    if (want !== i_out_data) begin
                        $display("%0t: vertex mismatch exp %h %h %h / %h %h %h",
                                 $time, want.skinned_x, want.skinned_y, want.skinned_z,
                                 want.unit_nx, want.unit_ny, want.unit_nz);
                        $display("%0t:                 got %h %h %h / %h %h %h",
                                 $time, i_out_data.skinned_x, i_out_data.skinned_y,
                                 i_out_data.skinned_z, i_out_data.unit_nx,
                                 i_out_data.unit_ny, i_out_data.unit_nz);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= vertex_q.size();
        end
    end

endmodule

// ===== test/linear_blend_vertex_skinning_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_tb
// Loads bone matrices and streams vertex influences with random gaps and
// output stalls; the checker compares every vertex result.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_tb
    import lbvs_pkg::*;
();

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        vertex_count;
    int        influence_count;
    int        matrix_count;
    bit        written [64];

    linear_blend_vertex_skinning u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    linear_blend_vertex_skinning_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_vertex_count (vertex_count)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0) begin
                out_stall = 1'b1;
                repeat (gap_len()) @(negedge clk);
                out_stall = 1'b0;
            end else begin
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    task automatic send(input t_in_item it);
        in_data = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        if (it.opcode == OP_MATRIX) matrix_count++;
        else influence_count++;
        repeat (gap_len()) @(negedge clk);
    endtask

    function automatic t_in_item rand_item();
        t_in_item    it;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    task automatic write_entry(input int bone, input int entry, input logic [31:0] val);
        t_in_item it;
        it = rand_item();
        it.opcode = OP_MATRIX;
        it.bone_index = 6'(bone);
        it.matrix_entry = 4'(entry);
        it.matrix_value = val;
        send(it);
        if (bone < 64 && entry < 12) written[bone] = 1'b1;
    endtask

    function automatic logic [31:0] rand_entry();
        unique case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $urandom_range(0, 131072) - 65536;
        endcase
    endfunction

    task automatic load_bone(input int bone, input bit extreme);
        for (int e = 0; e < 12; e++)
            write_entry(bone, e, extreme ? ((e % 2) ? 32'h80000000 : 32'h7fffffff)
                                         : rand_entry());
    endtask

    task automatic influence(input int bone, input logic [15:0] w, input bit last,
                             input bit wild);
        t_in_item it;
        it = rand_item();
        it.opcode = OP_INFLUENCE;
        it.bone_index = 6'(bone);
        it.weight = w;
        it.last_influence = last;
        if (!wild) begin
            it.pos_x = $urandom_range(0, 4194304) - 2097152;
            it.pos_y = $urandom_range(0, 4194304) - 2097152;
            it.pos_z = $urandom_range(0, 4194304) - 2097152;
        end
        send(it);
    endtask

    function automatic int pick_bone();
        int b;
        do b = $urandom_range(0, 63); while (!written[b]);
        return b;
    endfunction

    initial begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        influence_count = 0;
        matrix_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme matrix, identity-ish, invalid entry writes
        load_bone(0, 1'b1);
        write_entry(1, 0, 32'h00010000);
        write_entry(1, 4, 32'h00010000);
        for (int e = 1; e < 12; e++) if (e != 4) write_entry(1, e, (e == 8) ? 32'h10000 : 0);
        write_entry(1, 15, 32'h12345678);
        influence(0, 16'd32768, 1'b1, 1'b1);
        influence(1, 16'd0, 1'b1, 1'b0);
        influence(1, 16'hffff, 1'b0, 1'b1);
        influence(0, 16'hffff, 1'b1, 1'b1);
        influence(1, 16'd16384, 1'b0, 1'b0);
        influence(0, 16'd16384, 1'b1, 1'b0);

        for (int b = 2; b < 10; b++) load_bone(b, 1'b0);

        // random vertices, with occasional matrix rewrites
        n = 0;
        while (n < 320) begin
            if ($urandom_range(0, 9) == 0) begin
                write_entry(pick_bone(), $urandom_range(0, 15), rand_entry());
                n++;
            end else begin
                int k;
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) begin
                    influence(pick_bone(),
                              ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 32768)),
                              i == k - 1, $urandom_range(0, 5) == 0);
                    n++;
                end
            end
        end

        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        $display("covered %0d matrix writes and %0d influences, %0d vertices checked",
                 matrix_count, influence_count, vertex_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
